/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PHM_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

`define PHM_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");

`else

`define PHM_ASSERT_IMPLIES(label, clk, rst, cond, expr)

`define PHM_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

/* rtl/phm_pkg.sv */
package phm_pkg;

  localparam int DEF_CHANNELS   = 2;
  localparam int DEF_LINE_WIDTH = 16;

  localparam int PREFIX_LEN = 6;
  localparam logic [4:0] TIMER_MAX = 5'd31;

  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_ROW0   = 8'h33;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_HOME   = 8'h48;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [7:0] RST_BAR_CHAR  = 8'd35;
  localparam logic [7:0] RST_PEAK_CHAR = 8'd124;
  localparam logic [4:0] RST_HOLD      = 5'd20;

  // register indexes
  localparam logic [1:0] REG_BAR_CHAR  = 2'd0;
  localparam logic [1:0] REG_PEAK_CHAR = 2'd1;
  localparam logic [1:0] REG_HOLD      = 2'd2;

  // one line to draw
  typedef struct packed {
    logic       channel;
    logic [4:0] level;
    logic [4:0] peak;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* rtl/phm_front.sv */
module phm_front
  import phm_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int LINE_WIDTH = DEF_LINE_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       channel,
  input  logic [4:0] level,
  input  logic [4:0] hold_limit,
  input  fifo_stat_t q_stat,
  output logic       q_push,
  output job_t       q_job
);

  localparam int NCH = (CHANNELS < 2) ? CHANNELS : 2;

  logic [4:0] held_peak  [NCH];
  logic [4:0] hold_timer [NCH];

  logic       take;
  logic       channel_ok;
  logic [4:0] level_sat;
  logic [4:0] peak_cur;
  logic [4:0] timer_cur;
  logic [4:0] peak_next;
  logic [4:0] timer_next;

  assign in_ready   = !q_stat.full;
  assign take       = in_valid && in_ready;
  assign channel_ok = int'(channel) < CHANNELS;

  always_comb begin
    level_sat = level;
    if (6'(level) > 6'(LINE_WIDTH)) begin
      level_sat = 5'(LINE_WIDTH);
    end
  end

  assign peak_cur  = held_peak[channel];
  assign timer_cur = hold_timer[channel];

  always_comb begin
    peak_next  = peak_cur;
    timer_next = timer_cur;
    if (level_sat > peak_cur) begin
      peak_next  = level_sat;
      timer_next = '0;
    end else begin
      if (timer_cur != TIMER_MAX) begin
        timer_next = timer_cur + 5'd1;
      end
      // decay uses the timer before it counts
      if (timer_cur > hold_limit) begin
        peak_next = level_sat;
      end
    end
  end

  assign q_push        = take && channel_ok;
  assign q_job.channel = channel;
  assign q_job.level   = level_sat;
  assign q_job.peak    = peak_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        held_peak[i]  <= '0;
        hold_timer[i] <= '0;
      end
    end else if (q_push) begin
      held_peak[channel]  <= peak_next;
      hold_timer[channel] <= timer_next;
    end
  end

endmodule

/* rtl/phm_fifo.sv */
module phm_fifo
  import phm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  job_t       wr_job,
  input  logic       pop,
  output job_t       rd_job,
  output fifo_stat_t stat
);

  job_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign rd_job     = entry[rptr];
  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/phm_back.sv */
module phm_back
  import phm_pkg::*;
#(
  parameter int LINE_WIDTH = DEF_LINE_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  fifo_stat_t q_stat,
  input  job_t       q_job,
  output logic       q_pop,
  input  logic [7:0] bar_character,
  input  logic [7:0] peak_character,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] text_byte,
  output logic       last,
  output logic       first
);

  localparam int TOTAL = PREFIX_LEN + LINE_WIDTH;
  localparam int PW    = $clog2(TOTAL);
  localparam logic [PW-1:0] POS_END = PW'(TOTAL - 1);

  job_t          job;
  logic          busy;
  logic [PW-1:0] pos;
  logic          advance;
  logic          at_end;
  logic [7:0]    col;
  logic [7:0]    byte_next;

  assign advance = busy && (!out_valid || out_ready);
  assign at_end  = pos == POS_END;
  // next job loads as the last byte of the current one goes out
  assign q_pop   = !q_stat.empty && (!busy || (advance && at_end));

  assign col = 8'(pos) - 8'(PREFIX_LEN);

  always_comb begin
    case (8'(pos))
      8'd0:    byte_next = CH_ESC;
      8'd1:    byte_next = CH_LBRACK;
      8'd2:    byte_next = CH_ROW0 + 8'(job.channel);
      8'd3:    byte_next = CH_SEMI;
      8'd4:    byte_next = CH_ZERO;
      8'd5:    byte_next = CH_HOME;
      default: begin
        if (col == 8'(job.peak)) begin
          byte_next = peak_character;
        end else if (col < 8'(job.level)) begin
          byte_next = bar_character;
        end else begin
          byte_next = CH_SPACE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      text_byte <= byte_next;
      last      <= at_end;
      first     <= pos == '0;
    end
    if (q_pop) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        pos       <= at_end ? '0 : pos + PW'(1);
        if (at_end) begin
          busy <= q_pop;
        end
      end else begin
        if (out_valid && out_ready) begin
          out_valid <= 1'b0;
        end
        if (q_pop) begin
          busy <= 1'b1;
          pos  <= '0;
        end
      end
    end
  end

endmodule

/* rtl/peak_hold_meter_line_unit.sv */
// channel  | direction | signals
// in       | input     | in_valid, in_ready, channel, level
// out      | output    | out_valid, out_ready, text_byte, last
// cfg      | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// each update gives 6 + LINE_WIDTH bytes (22 by default), one per cycle from the
// byte sequencer in the back end while out_ready is high.
// the peak and timer update is done in the accept cycle; a two-entry job queue
// lets input be taken while a line is still going out.
// synchronous reset clears the peak and timer of every channel and sets the registers to their defaults.
// output stalls hold the byte register; the input stalls only with the queue full.
`include "assert_macros.svh"

module peak_hold_meter_line_unit
  import phm_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int LINE_WIDTH = DEF_LINE_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       channel,
  input  logic [4:0] level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] text_byte,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] bar_character;
  logic [7:0] peak_character;
  logic [4:0] hold_limit;

  fifo_stat_t q_stat;
  job_t       push_job;
  job_t       pop_job;
  logic       q_push;
  logic       q_pop;
  logic       first;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_character  <= RST_BAR_CHAR;
      peak_character <= RST_PEAK_CHAR;
      hold_limit     <= RST_HOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BAR_CHAR:  bar_character  <= cfg_data;
        REG_PEAK_CHAR: peak_character <= cfg_data;
        REG_HOLD:      hold_limit     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  phm_front #(
    .CHANNELS   (CHANNELS),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .channel    (channel),
    .level      (level),
    .hold_limit (hold_limit),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  phm_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (push_job),
    .pop    (q_pop),
    .rd_job (pop_job),
    .stat   (q_stat)
  );

  phm_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .q_job          (pop_job),
    .q_pop          (q_pop),
    .bar_character  (bar_character),
    .peak_character (peak_character),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .text_byte      (text_byte),
    .last           (last),
    .first          (first)
  );

  `PHM_ASSERT_NEVER(a_push_full, clk, rst, q_push && q_stat.full)
  `PHM_ASSERT_NEVER(a_pop_empty, clk, rst, q_pop && q_stat.empty)
  `PHM_ASSERT_IMPLIES(a_line_start, clk, rst, out_valid && first, text_byte == CH_ESC)
  `PHM_ASSERT_NEVER(a_first_last, clk, rst, out_valid && first && last)

endmodule

/* tb/peak_hold_meter_line_unit_tb.sv */
module peak_hold_meter_line_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import phm_pkg::*;

  localparam int CHANNELS    = DEF_CHANNELS;
  localparam int LINE_WIDTH  = DEF_LINE_WIDTH;
  localparam int LINE_BYTES  = PREFIX_LEN + LINE_WIDTH;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 294;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] chr;
    logic       eol;
  } line_byte_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       channel;
  logic [4:0] level;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] text_byte;
  logic       last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // local copy of the meter state and registers
  logic [7:0] bar_chr;
  logic [7:0] peak_chr;
  logic [4:0] hold_lim;
  logic [4:0] peak_mem [CHANNELS];
  logic [4:0] timer_mem [CHANNELS];

  line_byte_t pending_bytes [$];
  int         err_count;
  int         byte_count;
  int         cycle_count;
  bit         idle_on;
  int         rx_hold_left;
  int         rx_stall_left;

  peak_hold_meter_line_unit #(
    .CHANNELS  (CHANNELS),
    .LINE_WIDTH(LINE_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .channel  (channel),
    .level    (level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .text_byte(text_byte),
    .last     (last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  function automatic void push_byte(logic [7:0] chr, logic eol);
    line_byte_t b;
    b.chr = chr;
    b.eol = eol;
    pending_bytes.push_back(b);
  endfunction

  // peak/timer update and the text line that one level update produces
  function automatic void draw_meter_line(logic ch, logic [4:0] lvl_in);
    logic [4:0] lvl;
    logic [4:0] pk;
    logic [4:0] tm;
    bit         expired;
    logic [7:0] cell_chr;
    if (int'(ch) >= CHANNELS) return;
    lvl = (int'(lvl_in) > LINE_WIDTH) ? 5'(LINE_WIDTH) : lvl_in;
    pk = peak_mem[ch];
    tm = timer_mem[ch];
    if (lvl > pk) begin
      pk = lvl;
      tm = '0;
    end else begin
      expired = tm > hold_lim;
      if (tm < TIMER_MAX) tm = tm + 5'd1;
      if (expired) pk = lvl;
    end
    peak_mem[ch]  = pk;
    timer_mem[ch] = tm;
    push_byte(CH_ESC, 1'b0);
    push_byte(CH_LBRACK, 1'b0);
    push_byte(CH_ROW0 + 8'(ch), 1'b0);
    push_byte(CH_SEMI, 1'b0);
    push_byte(CH_ZERO, 1'b0);
    push_byte(CH_HOME, 1'b0);
    for (int col = 0; col < LINE_WIDTH; col++) begin
      if (col == int'(pk)) cell_chr = peak_chr;
      else if (col < int'(lvl)) cell_chr = bar_chr;
      else cell_chr = CH_SPACE;
      push_byte(cell_chr, col == LINE_WIDTH - 1);
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_level(input logic ch, input logic [4:0] lvl);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    channel  = ch;
    level    = lvl;
    do @(posedge clk); while (!in_ready);
    draw_meter_line(ch, lvl);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BAR_CHAR:  bar_chr = data;
      REG_PEAK_CHAR: peak_chr = data;
      REG_HOLD:      hold_lim = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (LINE_BYTES) @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    idle_on = 1'b1;
    send_level(1'b0, 5'd0);
    send_level(1'b1, 5'd16);
    send_level(1'b0, 5'd31);
    send_level(1'b1, 5'd5);
    send_level(1'b0, 5'd17);
    send_level(1'b1, 5'd9);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_BAR_CHAR, 8'h00);
    write_reg(REG_PEAK_CHAR, 8'hff);
    write_reg(REG_HOLD, 8'd0);
    send_level(1'b0, 5'd3);
    send_level(1'b0, 5'd1);
    send_level(1'b0, 5'd0);
    send_level(1'b1, 5'd15);
    wait_drained();
    write_reg(REG_BAR_CHAR, 8'hff);
    write_reg(REG_PEAK_CHAR, 8'h00);
    write_reg(REG_HOLD, 8'd31);
    write_reg(REG_UNUSED, 8'h5a);
    send_level(1'b1, 5'd10);
    send_level(1'b1, 5'd2);
    send_level(1'b0, 5'd16);
    send_level(1'b0, 5'd8);
    wait_drained();
  endtask

  // peak held for hold_limit + 1 updates, then follows level until a new high
  task automatic test_hold_decay();
    write_reg(REG_BAR_CHAR, RST_BAR_CHAR);
    write_reg(REG_PEAK_CHAR, RST_PEAK_CHAR);
    write_reg(REG_HOLD, 8'd2);
    send_level(1'b0, 5'd12);
    repeat (4) send_level(1'b0, 5'd3);
    send_level(1'b0, 5'd2);
    send_level(1'b0, 5'd1);
    send_level(1'b0, 5'd14);
    send_level(1'b0, 5'd6);
    wait_drained();
  endtask

  // timer saturates and never exceeds a hold limit of 31
  task automatic test_timer_ceiling();
    write_reg(REG_HOLD, 8'd31);
    send_level(1'b1, 5'd16);
    repeat (34) send_level(1'b1, 5'($urandom_range(0, 31)));
    wait_drained();
    write_reg(REG_HOLD, 8'd30);
    send_level(1'b1, 5'($urandom_range(0, 15)));
    send_level(1'b1, 5'd4);
    wait_drained();
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    rx_hold_left = 150;
    repeat (8) send_level(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
    wait_drained();
  endtask

  task automatic test_random();
    int         n_phases;
    int         per_phase;
    logic [4:0] lvl;
    n_phases  = 6;
    per_phase = RANDOM_ITEMS / n_phases;
    for (int ph = 0; ph < n_phases; ph++) begin
      write_reg(REG_BAR_CHAR, 8'($urandom_range(0, 255)));
      write_reg(REG_PEAK_CHAR, 8'($urandom_range(0, 255)));
      case ($urandom_range(0, 3))
        0:       write_reg(REG_HOLD, 8'd0);
        1:       write_reg(REG_HOLD, 8'd31);
        default: write_reg(REG_HOLD, 8'($urandom_range(1, 6)));
      endcase
      if (ph == 2) write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
      // phase 3 has no idling at all, the final phase neither
      idle_on = (ph != 3) && (ph != n_phases - 1);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 7) == 0) lvl = 5'($urandom_range(17, 31));
        else lvl = 5'($urandom_range(0, 16));
        send_level(1'($urandom_range(0, 1)), lvl);
      end
      wait_drained();
    end
  endtask

  // receiver side ready, with random stalls and an optional long hold-off
  initial begin
    out_ready = 1'b0;
    rx_stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready = 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        out_ready = 1'b0;
        rx_stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        rx_stall_left = $urandom_range(0, 3);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // compare every byte transaction with the oldest expected byte
  always @(posedge clk) begin
    line_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last %0b", text_byte, last));
      end else begin
        want = pending_bytes.pop_front();
        if (text_byte !== want.chr || last !== want.eol) begin
          note_failure($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                                 byte_count, want.chr, want.eol, text_byte, last));
        end
      end
      byte_count++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    channel      = 1'b0;
    level        = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_on      = 1'b0;
    rx_hold_left = 0;
    err_count    = 0;
    byte_count   = 0;
    bar_chr      = RST_BAR_CHAR;
    peak_chr     = RST_PEAK_CHAR;
    hold_lim     = RST_HOLD;
    for (int c = 0; c < CHANNELS; c++) begin
      peak_mem[c]  = '0;
      timer_mem[c] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_hold_decay();
    test_timer_ceiling();
    test_backpressure();
    test_random();

    wait_drained();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/phm_pkg.sv
rtl/phm_front.sv
rtl/phm_fifo.sv
rtl/phm_back.sv
rtl/peak_hold_meter_line_unit.sv
tb/peak_hold_meter_line_unit_tb.sv
